[rtl/rsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_pkg: shared definitions for the RLE RGB555 sprite decoder
// Holds the sizes, codes, beat structs and the RGB555 to RGB888 widening.
// ----------------------------------------------------------------------------
package rsd_pkg;

  // Largest sprite in bytes; the byte counter saturates one below it.
  localparam int unsigned MaxImageBytes = 1048576;
  localparam int unsigned CountW        = 20;
  localparam int unsigned CountMax      = (1 << CountW) - 1;
  localparam logic [CountW-1:0] CountCap =
    CountW'((MaxImageBytes - 1) < CountMax ? (MaxImageBytes - 1) : CountMax);

  // Control byte that announces a transparent-skip count.
  localparam logic [7:0] SkipMark = 8'hFF;

  // Decode modes as held in the mode register.
  typedef enum logic [1:0] {
    MODE_RAW  = 2'd0,
    MODE_COMP = 2'd1,
    MODE_ISO  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_DECODE_MODE = 1'b0,
    REG_RAW_PREFIX  = 1'b1
  } reg_idx_e;

  // Decoder phase, one-hot.
  typedef enum logic [2:0] {
    PH_CTRL = 3'b001,
    PH_RUN  = 3'b010,
    PH_SKIP = 3'b100
  } phase_e;

  typedef struct packed {
    mode_e             mode;
    logic [CountW-1:0] prefix;
  } cfg_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic        trunc;
  } result_t;

  // Widen a little-endian RGB555 pixel to RGB888 by repeating top bits.
  function automatic logic [23:0] widen555(logic [15:0] c);
    widen555 = {c[14:10], c[14:12], c[9:5], c[9:7], c[4:0], c[4:2]};
  endfunction

endpackage

[rtl/rle_rgb555_sprite_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_rgb555_sprite_decoder_top: RLE RGB555 sprite decoder
// Turns a sprite's byte stream into RGB888 pixel, control and skip words.
// ----------------------------------------------------------------------------
// The decoder takes one sprite byte per cycle while in_stall_o is low and
// gives at most one 32-bit word per byte: the byte waits in the input
// register, the word in the result register. Throughput is one byte per
// clock while nothing stalls, set by the single-pass decode step between
// those two registers. The low byte of a pixel gives no word. A final byte
// that ends a pixel, run or skip count early gives a zero word with truncated
// set. Write the mode and raw prefix only while no byte or word is in flight;
// a mode change between two bytes of a sprite takes effect at the next byte.
module rle_rgb555_sprite_decoder_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_index_i,
  input  logic [rsd_pkg::CountW-1:0] cfg_data_i,
  // Byte input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       last_byte_i,
  // Word output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [31:0]                pixel_word_o,
  output logic                       last_word_o,
  output logic                       truncated_o
);

  rsd_pkg::cfg_t    cfg;
  rsd_pkg::result_t res;
  rsd_pkg::result_t out;
  logic             res_valid;
  logic             res_free;

  rsd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rsd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_free_o  (res_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out)
  );

  assign pixel_word_o = out.word;
  assign last_word_o  = out.last;
  assign truncated_o  = out.trunc;

endmodule

[rtl/rsd_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_cfg: configuration registers
// Holds the decode mode and the raw prefix length written over the config port.
// ----------------------------------------------------------------------------
module rsd_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [rsd_pkg::CountW-1:0] cfg_data_i,
  output rsd_pkg::cfg_t             cfg_o
);

  rsd_pkg::mode_e              mode_q;
  logic [rsd_pkg::CountW-1:0]  prefix_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= rsd_pkg::MODE_RAW;
      prefix_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (rsd_pkg::reg_idx_e'(cfg_index_i))
        rsd_pkg::REG_DECODE_MODE: mode_q   <= rsd_pkg::mode_e'(cfg_data_i[1:0]);
        rsd_pkg::REG_RAW_PREFIX:  prefix_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.mode   = mode_q;
  assign cfg_o.prefix = prefix_q;

endmodule

[rtl/rsd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_core: input register and decode step
// Registers each byte beat, then decodes it against the phase state in one pass.
// ----------------------------------------------------------------------------
module rsd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsd_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              res_free_i,
  output logic              res_valid_o,
  output rsd_pkg::result_t  res_o
);

  // Input register.
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  // Decoder state.
  rsd_pkg::phase_e            phase_q, phase_d;
  logic [7:0]                 run_q, run_d;
  logic [7:0]                 hold_q, hold_d;
  logic                       pend_q, pend_d;
  logic [rsd_pkg::CountW-1:0] seen_q, seen_d;

  logic        raw;
  logic        have;
  logic [31:0] word;
  logic [7:0]  run_dec;
  logic        incomplete;
  logic        advance;

  // Raw or compressed decode for this byte.
  always_comb begin
    unique case (cfg_i.mode)
      rsd_pkg::MODE_COMP: raw = 1'b0;
      rsd_pkg::MODE_ISO:  raw = (seen_q < cfg_i.prefix) ||
                                ((phase_q == rsd_pkg::PH_CTRL) && pend_q);
      default:            raw = 1'b1;
    endcase
  end

  // Decode step.
  always_comb begin
    phase_d = phase_q;
    run_d   = run_q;
    hold_d  = hold_q;
    pend_d  = pend_q;
    have    = 1'b0;
    word    = '0;
    run_dec = run_q - 8'd1;
    if (raw) begin
      phase_d = rsd_pkg::PH_CTRL;
      run_d   = '0;
      if (!pend_q) begin
        hold_d = byte_q;
        pend_d = 1'b1;
      end else begin
        word   = {8'd0, rsd_pkg::widen555({byte_q, hold_q})};
        pend_d = 1'b0;
        have   = 1'b1;
      end
    end else begin
      unique case (phase_q)
        rsd_pkg::PH_SKIP: begin
          word    = {24'd0, byte_q};
          phase_d = rsd_pkg::PH_CTRL;
          have    = 1'b1;
        end
        rsd_pkg::PH_RUN: begin
          if (!pend_q) begin
            hold_d = byte_q;
            pend_d = 1'b1;
          end else begin
            word   = {8'd0, rsd_pkg::widen555({byte_q, hold_q})};
            pend_d = 1'b0;
            have   = 1'b1;
            run_d  = run_dec;
            if (run_dec == 8'd0) begin
              phase_d = rsd_pkg::PH_CTRL;
            end
          end
        end
        default: begin
          // Control byte: passed out; SkipMark sets up a skip, any other nonzero byte a pixel run.
          pend_d = 1'b0;
          word   = {24'd0, byte_q};
          have   = 1'b1;
          if (byte_q == rsd_pkg::SkipMark) begin
            phase_d = rsd_pkg::PH_SKIP;
          end else if (byte_q != 8'd0) begin
            run_d   = byte_q;
            phase_d = rsd_pkg::PH_RUN;
          end
        end
      endcase
    end

    seen_d = (seen_q < rsd_pkg::CountCap) ? seen_q + 1'b1 : seen_q;

    incomplete = (phase_d != rsd_pkg::PH_CTRL) || pend_d;
    res_o.word  = word;
    res_o.last  = last_q;
    res_o.trunc = 1'b0;
    if (last_q) begin
      // End of sprite: flag a cut pixel, run or skip count, and return to reset state.
      if (incomplete) begin
        res_o.word  = '0;
        res_o.trunc = 1'b1;
        have        = 1'b1;
      end
      phase_d = rsd_pkg::PH_CTRL;
      run_d   = '0;
      hold_d  = '0;
      pend_d  = 1'b0;
      seen_d  = '0;
    end
  end

  // A beat with no result never waits for the output register.
  assign advance     = in_valid_q && (res_free_i || !have);
  assign res_valid_o = advance && have;
  assign in_stall_o  = in_valid_q && !advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // State update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rsd_pkg::PH_CTRL;
      run_q   <= '0;
      hold_q  <= '0;
      pend_q  <= 1'b0;
      seen_q  <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      run_q   <= run_d;
      hold_q  <= hold_d;
      pend_q  <= pend_d;
      seen_q  <= seen_d;
    end
  end

  // A truncation word is always the zero word closing the sprite.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.trunc |-> res_o.last && (res_o.word == 32'd0))
    else $error("truncation word malformed");

  // The last byte of a sprite leaves the decoder in its reset state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && last_q |=> (phase_q == rsd_pkg::PH_CTRL) && !pend_q &&
                          (run_q == 8'd0) && (seen_q == '0))
    else $error("state not cleared after last byte");

  // A pixel run in progress always has pixels left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rsd_pkg::PH_RUN) |-> (run_q != 8'd0))
    else $error("empty pixel run");

  // No half pixel is held while waiting for a skip count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rsd_pkg::PH_SKIP) |-> !pend_q)
    else $error("low byte pending in skip phase");

endmodule

[rtl/rsd_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsd_out: result register
// Holds one decoded word beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module rsd_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  rsd_pkg::result_t res_i,
  output logic             res_free_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsd_pkg::result_t out_o
);

  logic             valid_q;
  rsd_pkg::result_t data_q;

  // Free when empty or when the held beat leaves this cycle.
  assign res_free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule
